// ----- hw/rtl/acsfr_pkg.sv -----
`default_nettype none

package acsfr_pkg;

	localparam int unsigned FRAME_BYTES = 24;

	localparam logic [4:0] POS_HUNT    = 5'd0;
	localparam logic [4:0] POS_HEAD_LAST = 5'd5;
	localparam logic [4:0] POS_LEAD    = 5'd6;
	localparam logic [4:0] POS_POWER   = 5'd7;
	localparam logic [4:0] POS_FLAGS   = 5'd8;
	localparam logic [4:0] POS_FANMODE = 5'd9;
	localparam logic [4:0] POS_ROOM    = 5'd10;
	localparam logic [4:0] POS_SET     = 5'd11;
	localparam logic [4:0] POS_TIMER   = 5'd14;
	localparam logic [4:0] POS_CHECK   = 5'd17;
	localparam logic [4:0] POS_FOOT    = 5'd18;
	localparam logic [4:0] POS_LAST    = 5'(FRAME_BYTES - 1);

	localparam logic [7:0] LEAD_BYTE   = 8'hBD;
	localparam logic [7:0] NIGHT_BIT   = 8'h04;
	localparam logic [7:0] NIBBLE_MASK = 8'h0F;

	typedef struct packed {
		logic       power_on;
		logic       night_mode;
		logic [3:0] fan_speed;
		logic [3:0] op_mode;
		logic [7:0] room_deg;
		logic [7:0] setpoint_deg;
		logic [7:0] timer_hours;
	} status_t;

	// header letters G A I T E K
	function automatic logic [7:0] head_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h47;
			3'd1: c = 8'h41;
			3'd2: c = 8'h49;
			3'd3: c = 8'h54;
			3'd4: c = 8'h45;
			3'd5: c = 8'h4B;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// footer is the header reversed
	function automatic logic [7:0] foot_char(input logic [2:0] idx);
		return head_char(3'd5 - idx);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ac_status_frame_receiver_unit.sv -----
// A status word reaches the outputs once the last frame byte has passed the input
// register and the parsed result has been captured in the status register.
// Throughput: one byte per cycle; stalls only while a result waits on out_ready.
// Reset: arst_n asynchronously clears the frame position and both valid flags;
// the block then hunts for a new header.
`default_nettype none

module ac_status_frame_receiver_unit
	import acsfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            power_on,
	output logic            night_mode,
	output logic [3:0]      fan_speed,
	output logic [3:0]      op_mode,
	output logic [7:0]      room_deg,
	output logic [7:0]      setpoint_deg,
	output logic [7:0]      timer_hours
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	logic       res_valid;
	status_t    res;
	logic [4:0] frame_pos;
	logic       out_valid_q;
	status_t    status_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);

	acsfr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1)
	);

	acsfr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.rx_byte_s1 (rx_byte_s1),
		.res_valid  (res_valid),
		.res        (res),
		.frame_pos  (frame_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_on     = status_q.power_on;
	assign night_mode   = status_q.night_mode;
	assign fan_speed    = status_q.fan_speed;
	assign op_mode      = status_q.op_mode;
	assign room_deg     = status_q.room_deg;
	assign setpoint_deg = status_q.setpoint_deg;
	assign timer_hours  = status_q.timer_hours;

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos <= POS_LAST)
		else $error("frame position out of range");

	a_res_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || out_ready))
		else $error("result overwrites a pending word");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without output backpressure");

	a_res_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (frame_pos == POS_HUNT))
		else $error("result not at frame end");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/acsfr_in_reg.sv -----
`default_nettype none

module acsfr_in_reg
	import acsfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      rx_byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/acsfr_parse.sv -----
`default_nettype none

module acsfr_parse
	import acsfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] rx_byte_s1,
	output logic            res_valid,
	output status_t         res,
	output logic [4:0]      frame_pos
);

	logic [4:0] pos_q;
	logic [4:0] pos;
	logic [4:0] pos_nxt;
	logic [7:0] xor_q;
	logic       lead_ok_q;
	logic       foot_ok_q;
	logic       power_q;
	logic       night_q;
	logic [7:0] fanmode_q;
	logic [7:0] room_q;
	logic [7:0] set_q;
	logic [7:0] timer_q;
	logic [7:0] b;

	assign b = rx_byte_s1;
	assign pos = (pos_q > POS_LAST) ? POS_HUNT : pos_q;
	assign frame_pos = pos_q;

	always_comb begin
		if (pos <= POS_HEAD_LAST) begin
			pos_nxt = (b == head_char(pos[2:0])) ? pos + 5'd1 : POS_HUNT;
		end else if (pos == POS_LAST) begin
			pos_nxt = POS_HUNT;
		end else begin
			pos_nxt = pos + 5'd1;
		end
	end

	// body xor over lead..check byte must come out zero
	assign res_valid = fire && (pos == POS_LAST) && lead_ok_q && foot_ok_q
		&& (xor_q == 8'h00) && (b == foot_char(3'd5));

	always_comb begin
		res.power_on     = power_q;
		res.night_mode   = night_q;
		res.fan_speed    = fanmode_q[7:4];
		res.op_mode      = fanmode_q[3:0] & NIBBLE_MASK[3:0];
		res.room_deg     = room_q;
		res.setpoint_deg = set_q;
		res.timer_hours  = timer_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (fire) begin
			pos_q <= pos_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (pos == POS_LEAD) begin
				xor_q     <= b;
				lead_ok_q <= (b == LEAD_BYTE);
			end else if (pos > POS_LEAD && pos <= POS_CHECK) begin
				xor_q <= xor_q ^ b;
			end
			if (pos == POS_POWER) begin
				power_q <= (b != 8'h00);
			end
			if (pos == POS_FLAGS) begin
				night_q <= ((b & NIGHT_BIT) != 8'h00);
			end
			if (pos == POS_FANMODE) begin
				fanmode_q <= b;
			end
			if (pos == POS_ROOM) begin
				room_q <= b;
			end
			if (pos == POS_SET) begin
				set_q <= b;
			end
			if (pos == POS_TIMER) begin
				timer_q <= b;
			end
			if (pos == POS_FOOT) begin
				foot_ok_q <= (b == foot_char(3'd0));
			end else if (pos > POS_FOOT && pos < POS_LAST) begin
				foot_ok_q <= foot_ok_q && (b == foot_char(3'(pos - POS_FOOT)));
			end
		end
	end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       power_on;
		logic       night_mode;
		logic [3:0] fan_speed;
		logic [3:0] op_mode;
		logic [7:0] room_deg;
		logic [7:0] setpoint_deg;
		logic [7:0] timer_hours;
	} rx_status_t;

	typedef enum logic [2:0] {
		FLT_NONE, FLT_FOOT, FLT_LEAD, FLT_SUM, FLT_HEAD
	} frame_fault_e;

	typedef enum logic [1:0] {
		PRE_NONE, PRE_NOISE, PRE_STUB
	} lead_in_e;

	typedef struct packed {
		frame_fault_e fault;
		lead_in_e     pre;
		logic [7:0]   power;
		logic [7:0]   flags;
		logic [7:0]   fanmode;
		logic [7:0]   room;
		logic [7:0]   setp;
		logic [7:0]   timer;
		logic         typed;
		rx_status_t   want;
	} dir_row_t;

	localparam int         FRAME_LEN  = 24;
	localparam int         BODY_AT    = 6;
	localparam int         FOOT_AT    = 18;
	localparam logic [7:0] BODY_LEAD  = 8'hBD;
	localparam logic [7:0] START_CHAR = 8'h47;
	localparam int         N_DIR      = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       power_on;
	logic       night_mode;
	logic [3:0] fan_speed;
	logic [3:0] op_mode;
	logic [7:0] room_deg;
	logic [7:0] setpoint_deg;
	logic [7:0] timer_hours;

	ac_status_frame_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power_on(power_on),
		.night_mode(night_mode),
		.fan_speed(fan_speed),
		.op_mode(op_mode),
		.room_deg(room_deg),
		.setpoint_deg(setpoint_deg),
		.timer_hours(timer_hours)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [4:0] frame_pos = 5'd0;
	logic [7:0] frame_buf [FRAME_LEN];

	rx_status_t status_due [$];
	logic [7:0] tx_frame [FRAME_LEN];
	bit         use_typed = 1'b0;
	rx_status_t typed_want;
	int         errors = 0;
	int         bytes_taken = 0;
	int         bytes_dropped = 0;
	int         words_due = 0;
	int         words_seen = 0;
	int         frames_sent = 0;
	int         frames_faulted = 0;
	int         tx_calm = 0;
	int         rx_calm = 0;

	// header letter i; the footer is the same letters in reverse order
	function automatic logic [7:0] sync_char(input int i);
		logic [7:0] c;
		case (i)
			0: c = 8'h47;
			1: c = 8'h41;
			2: c = 8'h49;
			3: c = 8'h54;
			4: c = 8'h45;
			5: c = 8'h4B;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	task automatic absorb_rx_byte(input logic [7:0] b, output bit used, output bit got,
			output rx_status_t st);
		int         pos;
		int         k;
		logic [7:0] acc;
		bit         ok;
		pos = frame_pos;
		got = 1'b0;
		used = 1'b1;
		st = '0;
		if (pos >= FRAME_LEN)
			pos = 0;
		if (pos == 0 && b != sync_char(0)) begin
			used = 1'b0;
			frame_pos = 5'd0;
		end else begin
			frame_buf[pos] = b;
			pos++;
			if (pos <= 6) begin
				frame_pos = (b == sync_char(pos - 1)) ? 5'(pos) : 5'd0;
			end else if (pos == FRAME_LEN) begin
				frame_pos = 5'd0;
				ok = 1'b1;
				for (k = 0; k < 6; k++)
					if (frame_buf[FOOT_AT + k] != sync_char(5 - k))
						ok = 1'b0;
				if (frame_buf[BODY_AT] != BODY_LEAD)
					ok = 1'b0;
				acc = 8'h00;
				for (k = 0; k < 11; k++)
					acc ^= frame_buf[BODY_AT + k];
				if (acc != frame_buf[BODY_AT + 11])
					ok = 1'b0;
				if (ok) begin
					got = 1'b1;
					st.power_on     = (frame_buf[BODY_AT + 1] != 8'h00);
					st.night_mode   = frame_buf[BODY_AT + 2][2];
					st.fan_speed    = frame_buf[BODY_AT + 3][7:4];
					st.op_mode      = frame_buf[BODY_AT + 3][3:0];
					st.room_deg     = frame_buf[BODY_AT + 4];
					st.setpoint_deg = frame_buf[BODY_AT + 5];
					st.timer_hours  = frame_buf[BODY_AT + 8];
				end
			end else begin
				frame_pos = 5'(pos);
			end
		end
	endtask

	// mostly short gaps, a few long ones, and now and then a stretch with none
	task automatic pick_gap(inout int calm, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if (r < 3) begin
			calm = $urandom_range(40, 150);
			gap = 0;
		end else if (r < 55) begin
			gap = 0;
		end else if (r < 88) begin
			gap = $urandom_range(1, 3);
		end else if (r < 97) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
	endtask

	task automatic offer_byte(input logic [7:0] b);
		int         gap;
		bit         used;
		bit         got;
		rx_status_t st;
		pick_gap(tx_calm, gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		absorb_rx_byte(b, used, got, st);
		bytes_taken++;
		if (!used)
			bytes_dropped++;
		if (got) begin
			status_due.push_back(use_typed ? typed_want : st);
			words_due++;
		end
	endtask

	task automatic send_frame(input frame_fault_e fault, input lead_in_e pre,
			input logic [7:0] pw, input logic [7:0] fl, input logic [7:0] fm,
			input logic [7:0] rt, input logic [7:0] sp, input logic [7:0] tm);
		int         k;
		int         idx;
		logic [7:0] acc;
		logic [7:0] b;
		for (k = 0; k < 6; k++) begin
			tx_frame[k] = sync_char(k);
			tx_frame[FOOT_AT + k] = sync_char(5 - k);
		end
		tx_frame[BODY_AT] = BODY_LEAD;
		for (k = BODY_AT + 1; k < FOOT_AT; k++)
			tx_frame[k] = 8'($urandom);
		tx_frame[BODY_AT + 1] = pw;
		tx_frame[BODY_AT + 2] = fl;
		tx_frame[BODY_AT + 3] = fm;
		tx_frame[BODY_AT + 4] = rt;
		tx_frame[BODY_AT + 5] = sp;
		tx_frame[BODY_AT + 8] = tm;
		if (fault == FLT_LEAD)
			tx_frame[BODY_AT] ^= 8'($urandom_range(1, 255));
		acc = 8'h00;
		for (k = 0; k < 11; k++)
			acc ^= tx_frame[BODY_AT + k];
		tx_frame[BODY_AT + 11] = acc;
		case (fault)
			FLT_SUM: tx_frame[BODY_AT + 11] ^= 8'($urandom_range(1, 255));
			FLT_FOOT: begin
				idx = FOOT_AT + $urandom_range(0, 5);
				tx_frame[idx] ^= 8'($urandom_range(1, 255));
			end
			FLT_HEAD: begin
				// a start letter in mid header must not restart the hunt
				idx = $urandom_range(1, 5);
				if ($urandom_range(0, 1) == 1)
					tx_frame[idx] = START_CHAR;
				else
					tx_frame[idx] ^= 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		case (pre)
			PRE_NOISE: begin
				repeat ($urandom_range(1, 5)) begin
					do b = 8'($urandom); while (b == START_CHAR);
					offer_byte(b);
				end
			end
			PRE_STUB: begin
				offer_byte(sync_char(0));
				offer_byte(sync_char(1));
			end
			default: ;
		endcase
		frames_sent++;
		if (fault != FLT_NONE)
			frames_faulted++;
		for (k = 0; k < FRAME_LEN; k++)
			offer_byte(tx_frame[k]);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rx_status_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			words_seen++;
			if (status_due.size() == 0) begin
				$display("%0t: status word with none expected, expected none got %0h",
					$time, {power_on, night_mode, fan_speed, op_mode, room_deg,
					setpoint_deg, timer_hours});
				errors++;
			end else begin
				want = status_due.pop_front();
				check_field("power_on", 8'(want.power_on), 8'(power_on));
				check_field("night_mode", 8'(want.night_mode), 8'(night_mode));
				check_field("fan_speed", 8'(want.fan_speed), 8'(fan_speed));
				check_field("op_mode", 8'(want.op_mode), 8'(op_mode));
				check_field("room_deg", want.room_deg, room_deg);
				check_field("setpoint_deg", want.setpoint_deg, setpoint_deg);
				check_field("timer_hours", want.timer_hours, timer_hours);
			end
		end
	end

	// receiver side; one long hold-off to back the block up
	initial begin
		int  gap;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && words_seen >= 6) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			pick_gap(rx_calm, gap);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		dir_row_t     dir_rows [N_DIR];
		int           i;
		int           r;
		frame_fault_e flt;
		lead_in_e     pre;
		logic [7:0]   pw;

		dir_rows[0] = '{FLT_NONE, PRE_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			1'b1, '{1'b0, 1'b0, 4'h0, 4'h0, 8'h00, 8'h00, 8'h00}};
		dir_rows[1] = '{FLT_NONE, PRE_NONE, 8'hFF, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1'b1, '{1'b1, 1'b0, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF}};
		dir_rows[2] = '{FLT_NONE, PRE_NOISE, 8'h01, 8'h04, 8'h13, 8'h19, 8'h18, 8'h02,
			1'b1, '{1'b1, 1'b1, 4'h1, 4'h3, 8'h19, 8'h18, 8'h02}};
		dir_rows[3] = '{FLT_NONE, PRE_NONE, 8'h80, 8'hFF, 8'h36, 8'h00, 8'hFF, 8'h00,
			1'b1, '{1'b1, 1'b1, 4'h3, 4'h6, 8'h00, 8'hFF, 8'h00}};
		dir_rows[4] = '{FLT_FOOT, PRE_NONE, 8'h01, 8'h00, 8'h21, 8'h17, 8'h16, 8'h01,
			1'b0, '0};
		dir_rows[5] = '{FLT_LEAD, PRE_NONE, 8'h01, 8'h00, 8'h21, 8'h17, 8'h16, 8'h01,
			1'b0, '0};
		dir_rows[6] = '{FLT_SUM, PRE_NONE, 8'h01, 8'h00, 8'h21, 8'h17, 8'h16, 8'h01,
			1'b0, '0};
		dir_rows[7] = '{FLT_HEAD, PRE_NONE, 8'h01, 8'h00, 8'h21, 8'h17, 8'h16, 8'h01,
			1'b0, '0};
		dir_rows[8] = '{FLT_NONE, PRE_STUB, 8'h01, 8'h04, 8'h31, 8'h1C, 8'h18, 8'h03,
			1'b0, '0};
		dir_rows[9] = '{FLT_NONE, PRE_NONE, 8'h7F, 8'h00, 8'h26, 8'h16, 8'h1A, 8'h0C,
			1'b0, '0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			use_typed = dir_rows[i].typed;
			typed_want = dir_rows[i].want;
			send_frame(dir_rows[i].fault, dir_rows[i].pre, dir_rows[i].power,
				dir_rows[i].flags, dir_rows[i].fanmode, dir_rows[i].room,
				dir_rows[i].setp, dir_rows[i].timer);
		end
		use_typed = 1'b0;

		while (bytes_taken < 1050) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				flt = FLT_NONE;
				if (r >= 65)
					flt = frame_fault_e'($urandom_range(FLT_FOOT, FLT_HEAD));
				r = $urandom_range(0, 99);
				pre = (r < 20) ? PRE_NOISE : (r < 25) ? PRE_STUB : PRE_NONE;
				pw = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
				send_frame(flt, pre, pw, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 8))
					offer_byte(8'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (status_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d bytes taken (%0d dropped while hunting) in %0d frames (%0d faulted)",
			bytes_taken, bytes_dropped, frames_sent, frames_faulted);
		$display("%0d status words predicted, %0d checked", words_due, words_seen);
		if (errors == 0)
			$display("** ac_status_frame_receiver_unit: PASSED **");
		else
			$display("** ac_status_frame_receiver_unit: FAILED **");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d status words outstanding", status_due.size());
		$display("** ac_status_frame_receiver_unit: FAILED **");
		$finish;
	end

endmodule
